// ----- design/rfe_pkg.sv -----
// shared constants, types and helper functions for the rectangle fill engine
package rfe_pkg;

    // default sizing
    localparam int unsigned COORD_LIMIT_DEF  = 2048;
    localparam int unsigned STRIDE_LIMIT_DEF = 16384;

    // fixed widths of the memory side
    localparam int unsigned ADDR_W = 32;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned SIZE_W = 2;
    localparam int unsigned FMT_W  = 2;

    // register index port
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 1'b1;

    // command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

    // pixel format codes
    localparam logic [FMT_W-1:0] FMT_8BPP  = 2'd0;
    localparam logic [FMT_W-1:0] FMT_16BPP = 2'd1;
    localparam logic [FMT_W-1:0] FMT_32BPP = 2'd2;

    // write size codes, log2 of bytes
    localparam logic [SIZE_W-1:0] SIZE_BYTE = 2'd0;
    localparam logic [SIZE_W-1:0] SIZE_HALF = 2'd1;
    localparam logic [SIZE_W-1:0] SIZE_WORD = 2'd2;

    // one memory write as handed to the output stage
    typedef struct packed {
        logic              write_valid;
        logic [ADDR_W-1:0] write_addr;
        logic [DATA_W-1:0] write_data;
        logic [SIZE_W-1:0] write_size;
        logic              last_write;
    } rfe_result_t;

    // config data is as wide as the stride register, but never below the format
    function automatic int unsigned cfg_data_w(input int unsigned stride_limit);
        int unsigned w;
        w = $clog2(stride_limit);
        return (w > FMT_W) ? w : FMT_W;
    endfunction

    // write size for a pixel format, unused code behaves as 32 bpp
    function automatic logic [SIZE_W-1:0] size_code(input logic [FMT_W-1:0] fmt);
        logic [SIZE_W-1:0] sz;
        case (fmt)
            FMT_8BPP:  sz = SIZE_BYTE;
            FMT_16BPP: sz = SIZE_HALF;
            default:   sz = SIZE_WORD;
        endcase
        return sz;
    endfunction

    // 0x00rrggbb to the stored pixel value of a format
    function automatic logic [DATA_W-1:0] convert_color(input logic [FMT_W-1:0] fmt,
                                                        input logic [DATA_W-1:0] c);
        logic [DATA_W-1:0] v;
        case (fmt)
            FMT_8BPP:  v = {24'd0, c[7:0]};
            // rgb565: top 5 of red, top 6 of green, top 5 of blue
            FMT_16BPP: v = {16'd0, c[23:19], c[15:10], c[7:3]};
            default:   v = c;
        endcase
        return v;
    endfunction

endpackage

// ----- design/rectangle_fill_engine.sv -----
// top level of the rectangle fill engine
//
//  channel | signals                                   | transfer when
//  --------+-------------------------------------------+-------------------------
//  in      | in_valid/in_ready, cmd, rectangle, color  | in_valid & in_ready
//  out     | out_valid/out_ready, write_* , last_write | out_valid & out_ready
//  cfg     | cfg_we, cfg_index, cfg_data               | cfg_we (no wait)
//
// one input transfer per cycle while in_ready is high; a next command's write
// is in the output register in the next cycle, a start command gives nothing
// the start address needs one top_y * line_stride product, the only multiplier
// reset clears busy and the output valid, format resets to 32 bpp, stride to 0
// a stalled output blocks input only while the held write is not taken;
// in_ready = !out_valid | out_ready
module rectangle_fill_engine #(
    parameter int unsigned COORD_LIMIT  = rfe_pkg::COORD_LIMIT_DEF,
    parameter int unsigned STRIDE_LIMIT = rfe_pkg::STRIDE_LIMIT_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    // configuration write port
    input  logic                                       cfg_we,
    input  logic [rfe_pkg::CFG_IDX_W-1:0]              cfg_index,
    input  logic [rfe_pkg::cfg_data_w(STRIDE_LIMIT)-1:0] cfg_data,
    // command channel
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  logic                                       cmd,
    input  logic [rfe_pkg::ADDR_W-1:0]                 buffer_base,
    input  logic [$clog2(COORD_LIMIT)-1:0]             left_x,
    input  logic [$clog2(COORD_LIMIT)-1:0]             top_y,
    input  logic [$clog2(COORD_LIMIT)-1:0]             right_x,
    input  logic [$clog2(COORD_LIMIT)-1:0]             bottom_y,
    input  logic [rfe_pkg::DATA_W-1:0]                 fill_color,
    // pixel write channel
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output logic                                       write_valid,
    output logic [rfe_pkg::ADDR_W-1:0]                 write_addr,
    output logic [rfe_pkg::DATA_W-1:0]                 write_data,
    output logic [rfe_pkg::SIZE_W-1:0]                 write_size,
    output logic                                       last_write
);

    localparam int unsigned COORD_W  = $clog2(COORD_LIMIT);
    localparam int unsigned STRIDE_W = $clog2(STRIDE_LIMIT);
    localparam int unsigned CFG_W    = rfe_pkg::cfg_data_w(STRIDE_LIMIT);

    logic [STRIDE_W-1:0]       line_stride;
    logic [rfe_pkg::FMT_W-1:0] pixel_format;
    logic                      in_xfer;
    logic                      result_en;
    rfe_pkg::rfe_result_t      result;
    rfe_pkg::rfe_result_t      held;

    // an input transfer is taken whenever the output register can accept a write
    assign in_xfer = in_valid && in_ready;

    rfe_cfg_regs #(
        .STRIDE_W (STRIDE_W),
        .CFG_W    (CFG_W)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .line_stride  (line_stride),
        .pixel_format (pixel_format)
    );

    // walk state advances on each transfer, write is formed from current state
    rfe_walker #(
        .COORD_W  (COORD_W),
        .STRIDE_W (STRIDE_W)
    ) u_walker (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (in_xfer),
        .cmd          (cmd),
        .buffer_base  (buffer_base),
        .left_x       (left_x),
        .top_y        (top_y),
        .right_x      (right_x),
        .bottom_y     (bottom_y),
        .fill_color   (fill_color),
        .line_stride  (line_stride),
        .pixel_format (pixel_format),
        .result_en    (result_en),
        .result       (result)
    );

    // output register decouples the write port from the command side
    rfe_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (result_en),
        .result    (result),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .can_load  (in_ready),
        .held      (held)
    );

    assign write_valid = held.write_valid;
    assign write_addr  = held.write_addr;
    assign write_data  = held.write_data;
    assign write_size  = held.write_size;
    assign last_write  = held.last_write;

endmodule

// ----- design/rfe_cfg_regs.sv -----
// configuration registers: line stride and pixel format
module rfe_cfg_regs #(
    parameter int unsigned STRIDE_W = 14,
    parameter int unsigned CFG_W    = 14
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rfe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]               cfg_data,
    output logic [STRIDE_W-1:0]            line_stride,
    output logic [rfe_pkg::FMT_W-1:0]      pixel_format
);

    logic [STRIDE_W-1:0]       line_stride_reg;
    logic [STRIDE_W-1:0]       line_stride_next;
    logic [rfe_pkg::FMT_W-1:0] pixel_format_reg;
    logic [rfe_pkg::FMT_W-1:0] pixel_format_next;

    always_comb
    begin
        line_stride_next  = line_stride_reg;
        pixel_format_next = pixel_format_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                rfe_pkg::REG_LINE_STRIDE:  line_stride_next  = cfg_data[STRIDE_W-1:0];
                rfe_pkg::REG_PIXEL_FORMAT: pixel_format_next = cfg_data[rfe_pkg::FMT_W-1:0];
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_stride_reg  <= '0;
            pixel_format_reg <= rfe_pkg::FMT_32BPP;
        end
        else
        begin
            line_stride_reg  <= line_stride_next;
            pixel_format_reg <= pixel_format_next;
        end
    end

    assign line_stride  = line_stride_reg;
    assign pixel_format = pixel_format_reg;

endmodule

// ----- design/rfe_walker.sv -----
// rectangle walk state and pixel write generation
module rfe_walker #(
    parameter int unsigned COORD_W  = 11,
    parameter int unsigned STRIDE_W = 14
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step_en,
    input  logic                          cmd,
    input  logic [rfe_pkg::ADDR_W-1:0]    buffer_base,
    input  logic [COORD_W-1:0]            left_x,
    input  logic [COORD_W-1:0]            top_y,
    input  logic [COORD_W-1:0]            right_x,
    input  logic [COORD_W-1:0]            bottom_y,
    input  logic [rfe_pkg::DATA_W-1:0]    fill_color,
    input  logic [STRIDE_W-1:0]           line_stride,
    input  logic [rfe_pkg::FMT_W-1:0]     pixel_format,
    output logic                          result_en,
    output rfe_pkg::rfe_result_t          result
);

    localparam int unsigned PROD_W = COORD_W + STRIDE_W;

    logic                         busy_reg, busy_next;
    logic [COORD_W-1:0]           cur_x_reg, cur_x_next;
    logic [COORD_W-1:0]           cur_y_reg, cur_y_next;
    logic [rfe_pkg::ADDR_W-1:0]   row_addr_reg, row_addr_next;
    logic [COORD_W-1:0]           rect_left_reg, rect_left_next;
    logic [COORD_W-1:0]           rect_right_reg, rect_right_next;
    logic [COORD_W-1:0]           rect_bottom_reg, rect_bottom_next;
    logic [rfe_pkg::DATA_W-1:0]   pixel_value_reg, pixel_value_next;

    logic [PROD_W-1:0]            row_offset;
    logic [rfe_pkg::SIZE_W-1:0]   sz;
    logic                         row_end;
    logic                         rect_end;

    assign row_offset = PROD_W'(top_y) * PROD_W'(line_stride);
    assign sz         = rfe_pkg::size_code(pixel_format);
    assign row_end    = (cur_x_reg >= rect_right_reg);
    assign rect_end   = row_end && (cur_y_reg >= rect_bottom_reg);
    assign result_en  = step_en && (cmd == rfe_pkg::CMD_NEXT);

    // write for the current pixel, all zero when idle
    always_comb
    begin
        result = '0;
        if (busy_reg)
        begin
            result.write_valid = 1'b1;
            result.write_addr  = row_addr_reg + (rfe_pkg::ADDR_W'(cur_x_reg) << sz);
            result.write_data  = pixel_value_reg;
            result.write_size  = sz;
            result.last_write  = rect_end;
        end
    end

    always_comb
    begin
        busy_next        = busy_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        row_addr_next    = row_addr_reg;
        rect_left_next   = rect_left_reg;
        rect_right_next  = rect_right_reg;
        rect_bottom_next = rect_bottom_reg;
        pixel_value_next = pixel_value_reg;
        if (step_en && cmd == rfe_pkg::CMD_START)
        begin
            rect_left_next   = left_x;
            rect_right_next  = right_x;
            rect_bottom_next = bottom_y;
            cur_x_next       = left_x;
            cur_y_next       = top_y;
            row_addr_next    = buffer_base + rfe_pkg::ADDR_W'(row_offset);
            pixel_value_next = rfe_pkg::convert_color(pixel_format, fill_color);
            busy_next        = (left_x <= right_x) && (top_y <= bottom_y);
        end
        else if (result_en && busy_reg)
        begin
            if (rect_end)
            begin
                busy_next = 1'b0;
            end
            else if (row_end)
            begin
                cur_x_next    = rect_left_reg;
                cur_y_next    = cur_y_reg + COORD_W'(1);
                row_addr_next = row_addr_reg + rfe_pkg::ADDR_W'(line_stride);
            end
            else
            begin
                cur_x_next = cur_x_reg + COORD_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg       <= cur_x_next;
        cur_y_reg       <= cur_y_next;
        row_addr_reg    <= row_addr_next;
        rect_left_reg   <= rect_left_next;
        rect_right_reg  <= rect_right_next;
        rect_bottom_reg <= rect_bottom_next;
        pixel_value_reg <= pixel_value_next;
    end

endmodule

// ----- design/rfe_out_stage.sv -----
// output register holding one pixel write until it is taken
module rfe_out_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  rfe_pkg::rfe_result_t  result,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic                  can_load,
    output rfe_pkg::rfe_result_t  held
);

    logic                 out_valid_reg;
    logic                 out_valid_next;
    rfe_pkg::rfe_result_t held_reg;

    assign can_load = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            held_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign held      = held_reg;

endmodule
